// File: hw/rtl/twpi_pkg.sv
// ----------------------------------------------------------------------------
// twpi_pkg
// Shared widths, constants, types and helper functions of the tracking wheel
// pose integrator.
// ----------------------------------------------------------------------------
package twpi_pkg;

    // Tunable constants.
    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 16;

    // Arctangent table depth and the number of iterations actually run.
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int ITER_W       = $clog2(ATAN_ENTRIES);

    // Field widths.
    localparam int DIST_W  = 32;
    localparam int HEAD_W  = 17;
    localparam int OFF_W   = 19;
    localparam int POS_W   = 32;
    localparam int TDATA_W = 88;

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 8'd1;

    // Internal widths.
    localparam int DELTA_W = DIST_W + 1;      // wheel delta
    localparam int DH_W    = HEAD_W + 1;      // heading delta
    localparam int RED_W   = 15;              // folded heading, +-9000
    localparam int LX_W    = DELTA_W + 1;     // corrected local delta
    localparam int CS_W    = FRACTION_BITS + 2;
    localparam int Z_W     = 35;              // CORDIC angle, Q32 radians
    localparam int ATAN_W  = 33;

    // Shared multiplier operand widths.
    localparam int MA_W   = OFF_W + DH_W;
    localparam int MB_W   = (CS_W > 21) ? CS_W : 21;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int G_W    = SUM_W - FRACTION_BITS;

    // pi/18000 in Q0.32.
    localparam logic signed [MB_W-1:0] RAD_PER_CDEG = MB_W'(749613);

    // CORDIC start vector: reciprocal of the asymptotic gain, rounded to FRACTION_BITS.
    localparam longint CORDIC_GAIN_Q32 = 64'sd2608131496;
    localparam longint GAIN_ROUNDED    =
        (CORDIC_GAIN_Q32 + (64'sd1 <<< (31 - FRACTION_BITS))) >>> (32 - FRACTION_BITS);
    localparam logic signed [CS_W-1:0] CORDIC_X0 = CS_W'(GAIN_ROUNDED);

    typedef struct packed {
        logic signed [RED_W-1:0] angle;
        logic                    flip;
    } heading_red_t;

    typedef struct packed {
        logic                  start;
        logic                  flip;
        logic signed [Z_W-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic busy;
    } cordic_status_t;

    function automatic logic signed [ATAN_W-1:0] atan_q32(input logic [ITER_W-1:0] idx);
        logic signed [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 33'sd3373259426;
            5'd1:    v = 33'sd1991351317;
            5'd2:    v = 33'sd1052175346;
            5'd3:    v = 33'sd534100635;
            5'd4:    v = 33'sd268086748;
            5'd5:    v = 33'sd134174063;
            5'd6:    v = 33'sd67103403;
            5'd7:    v = 33'sd33553749;
            5'd8:    v = 33'sd16777131;
            5'd9:    v = 33'sd8388597;
            5'd10:   v = 33'sd4194303;
            5'd11:   v = 33'sd2097152;
            5'd12:   v = 33'sd1048576;
            5'd13:   v = 33'sd524288;
            5'd14:   v = 33'sd262144;
            5'd15:   v = 33'sd131072;
            5'd16:   v = 33'sd65536;
            5'd17:   v = 33'sd32768;
            5'd18:   v = 33'sd16384;
            5'd19:   v = 33'sd8192;
            5'd20:   v = 33'sd4096;
            5'd21:   v = 33'sd2048;
            5'd22:   v = 33'sd1024;
            5'd23:   v = 33'sd512;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Reduces a heading to [-18000, 18000) and folds it into +-9000 centidegrees.
    function automatic heading_red_t reduce_heading(input logic signed [HEAD_W-1:0] h);
        logic signed [HEAD_W+1:0] m;
        heading_red_t             res;
        m = {{2{h[HEAD_W-1]}}, h} + 19'sd72000;
        for (int k = 0; k < 3; k++)
        begin
            if (m >= 19'sd36000)
            begin
                m = m - 19'sd36000;
            end
        end
        if (m >= 19'sd18000)
        begin
            m = m - 19'sd36000;
        end
        res.flip = 1'b0;
        if (m > 19'sd9000)
        begin
            m        = m - 19'sd18000;
            res.flip = 1'b1;
        end
        else if (m < -19'sd9000)
        begin
            m        = m + 19'sd18000;
            res.flip = 1'b1;
        end
        res.angle = m[RED_W-1:0];
        return res;
    endfunction

endpackage

// File: hw/rtl/tracking_wheel_pose_integrator_top.sv
// Items are handled one at a time: the iterative CORDIC and the single shared
// multiplier, used nine times per item, are reused for each item.
// The input is not ready while an item is in work or its result cannot be stored.
// Reset clears positions, previous distances, heading and offsets to zero at once.
// ----------------------------------------------------------------------------
// tracking_wheel_pose_integrator_top
// Two tracking wheel odometry: wheel and heading deltas, lever arm correction,
// rotation by the previous heading and saturating position accumulation.
// ----------------------------------------------------------------------------
module tracking_wheel_pose_integrator_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input item: x_wheel_distance, y_wheel_distance, heading_angle, zero pad.
    input  logic [twpi_pkg::TDATA_W-1:0]          s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Result item: x_position, y_position, heading_out, zero pad.
    output logic [twpi_pkg::TDATA_W-1:0]          m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [twpi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [twpi_pkg::OFF_W-1:0]            cfg_data
);
    import twpi_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE = 14'h0001,
        S_MZ   = 14'h0002,
        S_MX1  = 14'h0004,
        S_MX2  = 14'h0008,
        S_MY1  = 14'h0010,
        S_MY2  = 14'h0020,
        S_LY   = 14'h0040,
        S_WAIT = 14'h0080,
        S_R1   = 14'h0100,
        S_R2   = 14'h0200,
        S_R3   = 14'h0400,
        S_R4   = 14'h0800,
        S_R5   = 14'h1000,
        S_ACC  = 14'h2000
    } state_t;

    state_t state_reg, state_next;

    logic signed [OFF_W-1:0]   offx_reg, offy_reg;
    logic signed [DIST_W-1:0]  prev_x_reg, prev_y_reg;
    logic signed [HEAD_W-1:0]  prev_h_reg;
    logic signed [POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic signed [DIST_W-1:0]  xd_reg, yd_reg;
    logic signed [HEAD_W-1:0]  hd_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [DH_W-1:0]    dh_reg;
    logic signed [LX_W-1:0]    lx_reg, ly_reg;
    logic signed [SUM_W-1:0]   sum_x_reg, sum_y_reg;
    logic [TDATA_W-1:0]        out_data_reg;
    logic                      out_valid_reg;

    logic signed [DIST_W-1:0]  in_x, in_y;
    logic signed [HEAD_W-1:0]  in_h;
    logic                      in_xfer;
    logic                      out_free;
    heading_red_t              red;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [LX_W-1:0]    corr_delta;
    logic signed [POS_W-1:0]   new_x, new_y;
    cordic_req_t               cs_req;
    cordic_status_t            cs_status;
    logic signed [CS_W-1:0]    sin_val, cos_val;

    function automatic logic signed [LX_W-1:0] add_corr(
        input logic signed [DELTA_W-1:0] d,
        input logic signed [PROD_W-1:0]  p
    );
        logic signed [PROD_W-1:0] t;
        logic signed [LX_W-1:0]   c;
        t = p + (PROD_W'(1) <<< 31);
        t = t >>> 32;
        c = t[LX_W-1:0];
        return LX_W'(d) + c;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] acc,
        input logic signed [SUM_W-1:0] sum
    );
        logic signed [SUM_W-1:0] r;
        logic signed [G_W-1:0]   g;
        logic signed [G_W:0]     tot;
        logic signed [POS_W-1:0] res;
        r   = (sum + (SUM_W'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        g   = r[G_W-1:0];
        tot = (G_W+1)'(acc) + (G_W+1)'(g);
        priority if (tot[G_W:POS_W-1] == '0 || tot[G_W:POS_W-1] == '1)
        begin
            res = tot[POS_W-1:0];
        end
        else if (tot[G_W])
        begin
            res = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(POS_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign in_x = s_axis_tdata[DIST_W-1:0];
    assign in_y = s_axis_tdata[2*DIST_W-1:DIST_W];
    assign in_h = s_axis_tdata[2*DIST_W+HEAD_W-1:2*DIST_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign red        = reduce_heading(prev_h_reg);
    assign corr_delta = add_corr((state_reg == S_MY1) ? dx_reg : dy_reg, prod);
    assign new_x      = sat_add(pos_x_reg, sum_x_reg);
    assign new_y      = sat_add(pos_y_reg, sum_y_reg);

    twpi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    twpi_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cs_req),
        .status  (cs_status),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // Multiplier operand selection; the product is used in the next state.
    always_comb
    begin
        unique case (state_reg)
            S_MZ:
            begin
                mul_a = MA_W'(red.angle);
                mul_b = RAD_PER_CDEG;
            end
            S_MX1:
            begin
                mul_a = MA_W'(dh_reg);
                mul_b = MB_W'(offx_reg);
            end
            S_MX2, S_MY2:
            begin
                mul_a = prod[MA_W-1:0];
                mul_b = RAD_PER_CDEG;
            end
            S_MY1:
            begin
                mul_a = MA_W'(dh_reg);
                mul_b = MB_W'(offy_reg);
            end
            S_R1:
            begin
                mul_a = MA_W'(lx_reg);
                mul_b = MB_W'(cos_val);
            end
            S_R2:
            begin
                mul_a = MA_W'(ly_reg);
                mul_b = MB_W'(sin_val);
            end
            S_R3:
            begin
                mul_a = MA_W'(lx_reg);
                mul_b = MB_W'(sin_val);
            end
            S_R4:
            begin
                mul_a = MA_W'(ly_reg);
                mul_b = MB_W'(cos_val);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        cs_req.start = (state_reg == S_MX1);
        cs_req.flip  = red.flip;
        cs_req.angle = prod[Z_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_xfer) state_next = S_MZ;
            S_MZ:    state_next = S_MX1;
            S_MX1:   state_next = S_MX2;
            S_MX2:   state_next = S_MY1;
            S_MY1:   state_next = S_MY2;
            S_MY2:   state_next = S_LY;
            S_LY:    state_next = S_WAIT;
            S_WAIT:  if (!cs_status.busy) state_next = S_R1;
            S_R1:    state_next = S_R2;
            S_R2:    state_next = S_R3;
            S_R3:    state_next = S_R4;
            S_R4:    state_next = S_R5;
            S_R5:    state_next = S_ACC;
            S_ACC:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            offx_reg      <= '0;
            offy_reg      <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_h_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_X_OFFSET)
                begin
                    offx_reg <= cfg_data;
                end
                else if (cfg_index == REG_Y_OFFSET)
                begin
                    offy_reg <= cfg_data;
                end
            end
            if (state_reg == S_ACC && out_free)
            begin
                pos_x_reg     <= new_x;
                pos_y_reg     <= new_y;
                prev_x_reg    <= xd_reg;
                prev_y_reg    <= yd_reg;
                prev_h_reg    <= hd_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            xd_reg <= in_x;
            yd_reg <= in_y;
            hd_reg <= in_h;
            dx_reg <= DELTA_W'(in_x) - DELTA_W'(prev_x_reg);
            dy_reg <= DELTA_W'(in_y) - DELTA_W'(prev_y_reg);
            dh_reg <= DH_W'(in_h) - DH_W'(prev_h_reg);
        end
        if (state_reg == S_MY1)
        begin
            lx_reg <= corr_delta;
        end
        if (state_reg == S_LY)
        begin
            ly_reg <= corr_delta;
        end
        if (state_reg == S_R2)
        begin
            sum_x_reg <= SUM_W'(prod);
        end
        if (state_reg == S_R3)
        begin
            sum_x_reg <= sum_x_reg - SUM_W'(prod);
        end
        if (state_reg == S_R4)
        begin
            sum_y_reg <= SUM_W'(prod);
        end
        if (state_reg == S_R5)
        begin
            sum_y_reg <= sum_y_reg + SUM_W'(prod);
        end
        if (state_reg == S_ACC && out_free)
        begin
            out_data_reg <= {{(TDATA_W - 2*POS_W - HEAD_W){1'b0}}, hd_reg, new_y, new_x};
        end
    end

    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_MZ))
        else $error("Input transfer did not start the sequence.");

    a_cordic_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MX2) |-> cs_status.busy)
        else $error("CORDIC is not running after its start.");

    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R1) |-> !cs_status.busy)
        else $error("Rotation started before CORDIC finished.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_ACC))
        else $error("Result became valid outside the accumulate step.");
`endif

endmodule

// File: hw/rtl/twpi_mul.sv
// ----------------------------------------------------------------------------
// twpi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module twpi_mul (
    input  logic                               clk,
    input  logic signed [twpi_pkg::MA_W-1:0]   a,
    input  logic signed [twpi_pkg::MB_W-1:0]   b,
    output logic signed [twpi_pkg::PROD_W-1:0] p
);
    import twpi_pkg::*;

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    assign p_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/twpi_cordic.sv
// ----------------------------------------------------------------------------
// twpi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving sine
// and cosine in Q1.FRACTION_BITS.
// ----------------------------------------------------------------------------
module twpi_cordic (
    input  logic                             clk,
    input  logic                             rst_n,
    input  twpi_pkg::cordic_req_t            req,
    output twpi_pkg::cordic_status_t         status,
    output logic signed [twpi_pkg::CS_W-1:0] sin_val,
    output logic signed [twpi_pkg::CS_W-1:0] cos_val
);
    import twpi_pkg::*;

    logic signed [CS_W-1:0]   x_reg, x_next;
    logic signed [CS_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic                     busy_reg, busy_next;
    logic                     flip_reg, flip_next;
    logic signed [CS_W-1:0]   x_shift;
    logic signed [CS_W-1:0]   y_shift;
    logic signed [Z_W-1:0]    atan_step;

    // Arithmetic shifts floor, as the rotation requires.
    assign x_shift   = x_reg >>> iter_reg;
    assign y_shift   = y_reg >>> iter_reg;
    assign atan_step = Z_W'(atan_q32(iter_reg));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        if (req.start)
        begin
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = req.angle;
            iter_next = '0;
            busy_next = 1'b1;
            flip_next = req.flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - y_shift;
                y_next = y_reg + x_shift;
                z_next = z_reg - atan_step;
            end
            else
            begin
                x_next = x_reg + y_shift;
                y_next = y_reg - x_shift;
                z_next = z_reg + atan_step;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            flip_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            flip_reg <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Angles folded by 180 degrees come back with both results negated.
    assign sin_val     = flip_reg ? -y_reg : y_reg;
    assign cos_val     = flip_reg ? -x_reg : x_reg;
    assign status.busy = busy_reg;

endmodule
